// File: rtl/psbe_pkg.sv
// Package for the parallel strand bit-plane encoder.
// Holds sizes, reset values and the control struct shared by the cells and the top level.
// Depends on nothing.
package psbe_pkg;

  localparam int unsigned StrandLength = 512;
  localparam int unsigned StrandCount  = 8;
  localparam int unsigned StrandSlots  = 8;

  localparam int unsigned LenW    = 10;
  localparam int unsigned PosW    = (StrandLength > 1) ? $clog2(StrandLength) : 1;
  localparam int unsigned CmpW    = (PosW > LenW) ? PosW : LenW;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ChanCnt = 3;
  localparam int unsigned CellBits = ChanCnt * ByteW;
  localparam int unsigned BytesPerItem = ChanCnt * ByteW;
  localparam int unsigned CntW    = $clog2(BytesPerItem);
  localparam int unsigned IdxW    = 4;
  localparam int unsigned SlotW   = $clog2(StrandSlots);

  localparam logic [LenW-1:0]  LenReset   = LenW'(512);
  localparam logic [ByteW-1:0] ByteOffset = 8'h2C;
  localparam logic [CntW-1:0]  LastCnt    = CntW'(BytesPerItem - 1);
  localparam logic [PosW-1:0]  LastPos    = PosW'(StrandLength - 1);

  typedef struct packed {
    logic            load;
    logic            shift;
    logic [PosW-1:0] pos;
  } cell_ctrl_t;

endpackage

// File: rtl/psbe_if.sv
// Handshake interfaces for the input word and the result word of the encoder.
// Depends on psbe_pkg for field widths.
interface psbe_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] chan0_bytes;
  logic [63:0] chan1_bytes;
  logic [63:0] chan2_bytes;

  modport source (output valid, output chan0_bytes, output chan1_bytes,
                  output chan2_bytes, input ready);
  modport sink (input valid, input chan0_bytes, input chan1_bytes,
                input chan2_bytes, output ready);
endinterface

interface psbe_out_if;
  logic                        valid;
  logic                        ready;
  logic [psbe_pkg::ByteW-1:0]  frame_byte;
  logic                        last_of_led;
  logic                        last_of_frame;

  modport source (output valid, output frame_byte, output last_of_led,
                  output last_of_frame, input ready);
  modport sink (input valid, input frame_byte, input last_of_led,
                input last_of_frame, output ready);
endinterface

// File: rtl/psbe_strand_cell.sv
// One strand cell: holds the strand length register and the strand's 24 color bits.
// Shifts one bit per step into its own lane of the bit plane passed along the chain.
// Depends on psbe_pkg.
module psbe_strand_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [psbe_pkg::SlotW-1:0]    strand_idx_i,
  input  logic                          cfg_we_i,
  input  logic [psbe_pkg::IdxW-1:0]     cfg_idx_i,
  input  logic [psbe_pkg::LenW-1:0]     cfg_data_i,
  input  psbe_pkg::cell_ctrl_t          ctrl_i,
  input  logic [psbe_pkg::CellBits-1:0] bytes_i,
  input  logic [psbe_pkg::ByteW-1:0]    plane_i,
  output logic [psbe_pkg::ByteW-1:0]    plane_o
);

  logic [psbe_pkg::LenW-1:0]     len_q;
  logic [psbe_pkg::CellBits-1:0] data_q, data_d;
  logic                          active;
  logic                          cfg_hit;

  assign cfg_hit = cfg_we_i &&
                   (cfg_idx_i == psbe_pkg::IdxW'(strand_idx_i));
  assign active  = psbe_pkg::CmpW'(ctrl_i.pos) < psbe_pkg::CmpW'(len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= psbe_pkg::LenReset;
    end else if (cfg_hit) begin
      len_q <= cfg_data_i;
    end
  end

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = active ? bytes_i : '0;
    end else if (ctrl_i.shift) begin
      data_d = {data_q[psbe_pkg::CellBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign plane_o = plane_i |
                   (psbe_pkg::ByteW'(data_q[psbe_pkg::CellBits-1]) << strand_idx_i);

endmodule

// File: rtl/parallel_strand_bitplane_encoder.sv
// Top level of the parallel strand bit-plane encoder: control counter, chain of strand cells
// and the output register. Depends on psbe_pkg, psbe_if and psbe_strand_cell.
//
//   Port       Direction  Content
//   in_i       sink       three 64-bit color words, one LED position for all strands
//   out_o      source     plane byte plus 0x2C, with last-of-LED and last-of-frame flags
//   cfg_*_i    write      strand length registers, index 0 to 7
//
// Each input word yields 24 output words, one per cycle while the output is not stalled.
// A new input word is taken in the cycle that shifts out the last plane of the previous one,
// so words follow each other without a gap. A stall on the output holds the cells and the
// output register. Reset clears the position counter and sets every strand length to 512.
module parallel_strand_bitplane_encoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [psbe_pkg::IdxW-1:0]  cfg_idx_i,
  input  logic [psbe_pkg::LenW-1:0]  cfg_data_i,
  psbe_in_if.sink                    in_i,
  psbe_out_if.source                 out_o
);

  logic                          busy_q, busy_d;
  logic [psbe_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [psbe_pkg::PosW-1:0]     pos_q, pos_d;
  logic                          frame_end_q, frame_end_d;
  logic                          out_valid_q;
  logic [psbe_pkg::ByteW-1:0]    out_byte_q;
  logic                          out_led_q;
  logic                          out_frame_q;
  logic                          shift;
  logic                          accept;
  logic                          last_shift;
  psbe_pkg::cell_ctrl_t          ctrl;
  logic [psbe_pkg::ByteW-1:0]    plane [psbe_pkg::StrandSlots+1];

  assign shift      = busy_q && (!out_valid_q || out_o.ready);
  assign last_shift = shift && (cnt_q == psbe_pkg::LastCnt);
  assign in_i.ready = !busy_q || last_shift;
  assign accept     = in_i.valid && in_i.ready;

  assign ctrl.load  = accept;
  assign ctrl.shift = shift;
  assign ctrl.pos   = pos_q;

  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    frame_end_d = frame_end_q;
    if (shift) begin
      cnt_d = cnt_q + psbe_pkg::CntW'(1);
      if (last_shift) begin
        busy_d = 1'b0;
      end
    end
    if (accept) begin
      busy_d      = 1'b1;
      cnt_d       = '0;
      frame_end_d = (pos_q == psbe_pkg::LastPos);
      pos_d       = (pos_q == psbe_pkg::LastPos) ? '0 : pos_q + psbe_pkg::PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      pos_q       <= '0;
      frame_end_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      frame_end_q <= frame_end_d;
      if (shift) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      out_byte_q  <= plane[psbe_pkg::StrandSlots] + psbe_pkg::ByteOffset;
      out_led_q   <= last_shift;
      out_frame_q <= last_shift && frame_end_q;
    end
  end

  assign plane[0] = '0;

  for (genvar s = 0; s < psbe_pkg::StrandSlots; s++) begin : g_cell
    if (s < psbe_pkg::StrandCount) begin : g_used
      psbe_strand_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .strand_idx_i (psbe_pkg::SlotW'(s)),
        .cfg_we_i     (cfg_we_i),
        .cfg_idx_i    (cfg_idx_i),
        .cfg_data_i   (cfg_data_i),
        .ctrl_i       (ctrl),
        .bytes_i      ({in_i.chan2_bytes[8*s +: 8], in_i.chan1_bytes[8*s +: 8],
                        in_i.chan0_bytes[8*s +: 8]}),
        .plane_i      (plane[s]),
        .plane_o      (plane[s+1])
      );
    end else begin : g_absent
      assign plane[s+1] = plane[s];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.frame_byte    = out_byte_q;
  assign out_o.last_of_led   = out_led_q;
  assign out_o.last_of_frame = out_frame_q;

endmodule
